>>> rtl/rsnp_pkg.sv
// Shared types and constants of the ray-sphere nearest pick block.
package rsnp_pkg;

	// Raw coordinate difference width (origin minus centre, sign extended).
	localparam int CRD_W = 33;
	// Operand width of the serial multiplier and width of its accumulator.
	localparam int OPW = 68;
	localparam int ACC_W = 136;
	// Multiplier digit width and digit counts for short and long products.
	localparam int DIG_W = 4;
	localparam int DIGS_SHORT = 9;
	localparam int DIGS_LONG = 17;
	localparam int DCNT_W = 5;
	// Square root: radicand, root and partial remainder widths.
	localparam int RAD_W = 132;
	localparam int ROOT_W = 66;
	localparam int REM_W = 70;
	localparam int RCNT_W = 7;
	// Root numerator, quadratic coefficient a and distance widths.
	localparam int NUM_W = 70;
	localparam int A_W = 64;
	localparam int T_W = 32;
	localparam int FRAC_W = 16;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;

	// Multiply-accumulate sequence steps.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_DXX = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DYY = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DZZ = 4'd2;
	localparam logic [STEP_W-1:0] STEP_ODX = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ODY = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ODZ = 4'd5;
	localparam logic [STEP_W-1:0] STEP_OOX = 4'd6;
	localparam logic [STEP_W-1:0] STEP_OOY = 4'd7;
	localparam logic [STEP_W-1:0] STEP_OOZ = 4'd8;
	localparam logic [STEP_W-1:0] STEP_RR = 4'd9;
	localparam logic [STEP_W-1:0] STEP_HBB = 4'd10;
	localparam logic [STEP_W-1:0] STEP_ACC = 4'd11;

	typedef struct packed {
		logic start;
		logic clear;
		logic neg;
		logic long_op;
	} mac_ctl_t;

endpackage

>>> rtl/rsnp_mac.sv
// Digit-serial signed multiply-accumulate unit.
module rsnp_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rsnp_pkg::mac_ctl_t                   ctl,
	input  logic signed [rsnp_pkg::OPW-1:0]      x,
	input  logic signed [rsnp_pkg::OPW-1:0]      y,
	output logic                                 done,
	output logic signed [rsnp_pkg::ACC_W-1:0]    acc
);

	localparam int OPW = rsnp_pkg::OPW;
	localparam int ACC_W = rsnp_pkg::ACC_W;
	localparam int DIG_W = rsnp_pkg::DIG_W;
	localparam int DCNT_W = rsnp_pkg::DCNT_W;
	localparam int SHORT_SH = OPW - rsnp_pkg::DIGS_SHORT * DIG_W;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [OPW-1:0]    xm_q;
	logic [OPW-1:0]    ym_q;
	logic [ACC_W-1:0]  p_q;
	logic              sgn_q;
	logic              clr_q;
	logic [ACC_W-1:0]  acc_q;

	logic [OPW-1:0]       xabs;
	logic [OPW-1:0]       yabs;
	logic [OPW-1:0]       yalign;
	logic [DIG_W-1:0]     digit;
	logic [OPW+DIG_W-1:0] pp;
	logic [ACC_W-1:0]     p_next;
	logic [ACC_W-1:0]     term;
	logic [ACC_W-1:0]     base;

	always_comb begin
		xabs = x[OPW-1] ? (~x + 1'b1) : x;
		yabs = y[OPW-1] ? (~y + 1'b1) : y;
		// Short products are left aligned so the top digit comes out first.
		yalign = ctl.long_op ? yabs : (yabs << SHORT_SH);
		digit = ym_q[OPW-1 -: DIG_W];
		pp = xm_q * digit;
		p_next = (p_q << DIG_W) + ACC_W'(pp);
		term = sgn_q ? (~p_q + 1'b1) : p_q;
		base = clr_q ? '0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.long_op ? DCNT_W'(rsnp_pkg::DIGS_LONG)
					: DCNT_W'(rsnp_pkg::DIGS_SHORT);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			xm_q <= xabs;
			ym_q <= yalign;
			p_q <= '0;
			sgn_q <= x[OPW-1] ^ y[OPW-1] ^ ctl.neg;
			clr_q <= ctl.clear;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				p_q <= p_next;
				ym_q <= ym_q << DIG_W;
			end else begin
				acc_q <= base + term;
			end
		end
	end

	assign done = done_q;
	assign acc = acc_q;

endmodule

>>> rtl/rsnp_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module rsnp_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rsnp_pkg::RAD_W-1:0]    radicand,
	output logic                          done,
	output logic [rsnp_pkg::ROOT_W-1:0]   root
);

	localparam int RAD_W = rsnp_pkg::RAD_W;
	localparam int ROOT_W = rsnp_pkg::ROOT_W;
	localparam int REM_W = rsnp_pkg::REM_W;
	localparam int RCNT_W = rsnp_pkg::RCNT_W;

	logic              busy_q;
	logic              done_q;
	logic [RCNT_W-1:0] cnt_q;
	logic [RAD_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
		ge = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= RCNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == RCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			rem_q <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/ray_sphere_nearest_pick_top.sv
// Ray-sphere nearest hit picker over a stream of spheres, top level.
// Each sphere runs twelve products on a 4-bit-digit serial multiplier
// (short and long), a square root and a restoring divide. Spheres with
// no positive radius, or past the sphere cap, skip the arithmetic. The
// result of a pick is registered in the output state once its last sphere
// finishes. Reset clears the ray registers and the pick state.
module ray_sphere_nearest_pick_top #(
	parameter int MAX_SPHERES = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rsnp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [31:0]                    centre_x,
	input  logic signed [31:0]                    centre_y,
	input  logic signed [31:0]                    centre_z,
	input  logic signed [31:0]                    sphere_radius,
	input  logic                                  last_sphere,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  hit_found,
	output logic [7:0]                            hit_index,
	output logic [31:0]                           hit_distance
);

	localparam int CRD_W = rsnp_pkg::CRD_W;
	localparam int OPW = rsnp_pkg::OPW;
	localparam int ACC_W = rsnp_pkg::ACC_W;
	localparam int RAD_W = rsnp_pkg::RAD_W;
	localparam int ROOT_W = rsnp_pkg::ROOT_W;
	localparam int NUM_W = rsnp_pkg::NUM_W;
	localparam int A_W = rsnp_pkg::A_W;
	localparam int T_W = rsnp_pkg::T_W;
	localparam int FRAC_W = rsnp_pkg::FRAC_W;
	localparam int STEP_W = rsnp_pkg::STEP_W;
	localparam int CNT_W = $clog2(MAX_SPHERES + 1);
	localparam int DREM_W = A_W + 1;
	localparam int QCNT_W = 6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAC_GO,
		S_MAC_WAIT,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_DIV_SETUP,
		S_DIV,
		S_FINISH,
		S_OUT
	} state_t;

	// Ray registers.
	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;

	state_t                   state_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [CRD_W-1:0]  oc_x_q, oc_y_q, oc_z_q;
	logic signed [CRD_W-1:0]  rad_q;
	logic                     last_q;
	logic                     in_range_q;
	logic [A_W-1:0]           a_q;
	logic signed [OPW-1:0]    hb_q;
	logic signed [OPW-1:0]    cc_q;
	logic [NUM_W-1:0]         num_q;
	logic [DREM_W-1:0]        drem_q;
	logic [T_W-1:0]           dsh_q;
	logic [T_W-1:0]           dq_q;
	logic [QCNT_W-1:0]        dcnt_q;
	logic                     hit_q;
	logic [T_W-1:0]           t_q;
	logic                     best_valid_q;
	logic [7:0]               best_pos_q;
	logic [T_W-1:0]           best_t_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [7:0]               out_index_q;
	logic [T_W-1:0]           out_dist_q;

	rsnp_pkg::mac_ctl_t       mac_ctl;
	logic signed [OPW-1:0]    mac_x, mac_y;
	logic                     mac_done;
	logic signed [ACC_W-1:0]  mac_acc;
	logic                     sq_start;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;

	logic signed [CRD_W-1:0]  dx, dy, dz;
	logic signed [NUM_W-1:0]  nb, near_n, far_n, root_x;
	logic [DREM_W:0]          r2;
	logic                     dge;
	logic [CNT_W+7:0]         pos_ext;
	logic                     take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			dir_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsnp_pkg::REG_ORIGIN_X: org_x_q <= cfg_data;
				rsnp_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data;
				rsnp_pkg::REG_ORIGIN_Z: org_z_q <= cfg_data;
				rsnp_pkg::REG_DIR_X: dir_x_q <= cfg_data;
				rsnp_pkg::REG_DIR_Y: dir_y_q <= cfg_data;
				rsnp_pkg::REG_DIR_Z: dir_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_comb begin
		dx = CRD_W'(dir_x_q);
		dy = CRD_W'(dir_y_q);
		dz = CRD_W'(dir_z_q);
		mac_ctl.start = state_q == S_MAC_GO;
		mac_ctl.clear = step_q == rsnp_pkg::STEP_DXX || step_q == rsnp_pkg::STEP_ODX
			|| step_q == rsnp_pkg::STEP_OOX || step_q == rsnp_pkg::STEP_HBB;
		mac_ctl.neg = step_q == rsnp_pkg::STEP_RR || step_q == rsnp_pkg::STEP_ACC;
		mac_ctl.long_op = step_q == rsnp_pkg::STEP_HBB || step_q == rsnp_pkg::STEP_ACC;
		case (step_q)
			rsnp_pkg::STEP_DXX: begin mac_x = OPW'(dx); mac_y = OPW'(dx); end
			rsnp_pkg::STEP_DYY: begin mac_x = OPW'(dy); mac_y = OPW'(dy); end
			rsnp_pkg::STEP_DZZ: begin mac_x = OPW'(dz); mac_y = OPW'(dz); end
			rsnp_pkg::STEP_ODX: begin mac_x = OPW'(oc_x_q); mac_y = OPW'(dx); end
			rsnp_pkg::STEP_ODY: begin mac_x = OPW'(oc_y_q); mac_y = OPW'(dy); end
			rsnp_pkg::STEP_ODZ: begin mac_x = OPW'(oc_z_q); mac_y = OPW'(dz); end
			rsnp_pkg::STEP_OOX: begin mac_x = OPW'(oc_x_q); mac_y = OPW'(oc_x_q); end
			rsnp_pkg::STEP_OOY: begin mac_x = OPW'(oc_y_q); mac_y = OPW'(oc_y_q); end
			rsnp_pkg::STEP_OOZ: begin mac_x = OPW'(oc_z_q); mac_y = OPW'(oc_z_q); end
			rsnp_pkg::STEP_RR: begin mac_x = OPW'(rad_q); mac_y = OPW'(rad_q); end
			rsnp_pkg::STEP_HBB: begin mac_x = hb_q; mac_y = hb_q; end
			rsnp_pkg::STEP_ACC: begin mac_x = OPW'({1'b0, a_q}); mac_y = cc_q; end
			default: begin mac_x = '0; mac_y = '0; end
		endcase
		sq_start = state_q == S_SQRT_GO;
		// Near and far numerators of the half-b roots, scaled by a.
		nb = -NUM_W'(hb_q);
		root_x = NUM_W'(sq_root);
		near_n = nb - root_x;
		far_n = nb + root_x;
		r2 = {drem_q, dsh_q[T_W-1]};
		dge = r2 >= (DREM_W + 1)'(a_q);
		pos_ext = {8'b0, cnt_q};
		take = in_range_q && hit_q && (!best_valid_q || t_q < best_t_q);
	end

	rsnp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x      (mac_x),
		.y      (mac_y),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	rsnp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (mac_acc[RAD_W-1:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			hit_q <= 1'b0;
			in_range_q <= 1'b0;
			last_q <= 1'b0;
			best_valid_q <= 1'b0;
			best_pos_q <= '0;
			best_t_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_hit_q <= 1'b0;
			out_index_q <= '0;
			out_dist_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						oc_x_q <= CRD_W'(org_x_q) - CRD_W'(centre_x);
						oc_y_q <= CRD_W'(org_y_q) - CRD_W'(centre_y);
						oc_z_q <= CRD_W'(org_z_q) - CRD_W'(centre_z);
						rad_q <= CRD_W'(sphere_radius);
						last_q <= last_sphere;
						hit_q <= 1'b0;
						step_q <= rsnp_pkg::STEP_DXX;
						in_range_q <= cnt_q < CNT_W'(MAX_SPHERES);
						if (cnt_q < CNT_W'(MAX_SPHERES) && sphere_radius > 0) begin
							state_q <= S_MAC_GO;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_MAC_GO: begin
					state_q <= S_MAC_WAIT;
				end
				S_MAC_WAIT: begin
					if (mac_done) begin
						case (step_q)
							rsnp_pkg::STEP_DZZ: a_q <= mac_acc[A_W-1:0];
							rsnp_pkg::STEP_ODZ: hb_q <= mac_acc[OPW-1:0];
							rsnp_pkg::STEP_RR: cc_q <= mac_acc[OPW-1:0];
							default: ;
						endcase
						if (step_q == rsnp_pkg::STEP_ACC) begin
							// A zero direction or a negative discriminant misses.
							if (mac_acc[ACC_W-1] || a_q == '0) begin
								state_q <= S_FINISH;
							end else begin
								state_q <= S_SQRT_GO;
							end
						end else begin
							step_q <= step_q + 1'b1;
							state_q <= S_MAC_GO;
						end
					end
				end
				S_SQRT_GO: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sq_done) begin
						if (!near_n[NUM_W-1]) begin
							num_q <= near_n;
							state_q <= S_DIV_SETUP;
						end else if (!far_n[NUM_W-1]) begin
							num_q <= far_n;
							state_q <= S_DIV_SETUP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_DIV_SETUP: begin
					// A quotient of 2^32 or more saturates.
					if (A_W'(num_q[NUM_W-1:FRAC_W]) >= a_q) begin
						t_q <= '1;
						hit_q <= 1'b1;
						state_q <= S_FINISH;
					end else begin
						drem_q <= DREM_W'(num_q[NUM_W-1:FRAC_W]);
						dsh_q <= {num_q[FRAC_W-1:0], FRAC_W'(0)};
						dq_q <= '0;
						dcnt_q <= QCNT_W'(T_W);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					drem_q <= dge ? DREM_W'(r2 - (DREM_W + 1)'(a_q)) : r2[DREM_W-1:0];
					dq_q <= {dq_q[T_W-2:0], dge};
					dsh_q <= dsh_q << 1;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == QCNT_W'(1)) begin
						t_q <= {dq_q[T_W-2:0], dge};
						hit_q <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (in_range_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (take) begin
						best_valid_q <= 1'b1;
						best_pos_q <= pos_ext[7:0];
						best_t_q <= t_q;
					end
					state_q <= last_q ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_hit_q <= best_valid_q;
						out_index_q <= best_valid_q ? best_pos_q : '0;
						out_dist_q <= best_valid_q ? best_t_q : '0;
						best_valid_q <= 1'b0;
						best_pos_q <= '0;
						best_t_q <= '0;
						cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign hit_found = out_hit_q;
	assign hit_index = out_index_q;
	assign hit_distance = out_dist_q;

endmodule

>>> rtl/rsnp_checker.sv
// Port-level checks of the ray-sphere nearest pick top level, with its bind.
module rsnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit_found,
	input logic [7:0]  hit_index,
	input logic [31:0] hit_distance
);

	// A pick with no hit reports zero index and distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_found |-> hit_index == 8'd0 && hit_distance == 32'd0)
		else $error("miss result carries nonzero fields");

	// The block is not ready in the cycle after it takes a sphere.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A result waiting on the consumer holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_distance)
			&& $stable(hit_index) && $stable(hit_found))
		else $error("stalled result changed");

endmodule

bind ray_sphere_nearest_pick_top rsnp_checker u_rsnp_checker (.*);
